// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is asserted.
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rotb_pkg.sv =====
// Package: constants, codes and widths for the ring oscillator trim bisection unit.
package rotb_pkg;

  // Field widths
  localparam int unsigned LoadW   = 15;
  localparam int unsigned CoarseW = 4;
  localparam int unsigned FineW   = 5;
  localparam int unsigned FreqW   = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned RoundW  = 4;
  localparam int unsigned CfgIdxW = 2;

  // Load and trim geometry (fF)
  localparam int unsigned LoadMax    = 19960;
  localparam int unsigned LoadMid    = LoadMax / 2;
  localparam int unsigned CoarseStep = 1000;
  localparam int unsigned FineStep   = 160;
  localparam int unsigned CoarseMax  = 15;
  localparam int unsigned FineMax    = 31;
  // A coarse step is a candidate while the remainder is below this
  localparam int unsigned TrimWin    = FineStep * FineMax + CoarseStep;

  // (x >> 5) * 205 >> 10 == x / 160 for the remainders seen here
  localparam int unsigned FineShift  = 5;
  localparam int unsigned Recip5     = 205;
  localparam int unsigned RecipShift = 10;

  // Register reset values
  localparam logic [31:0] ResetRefHz  = 32'd24000000;
  localparam logic [15:0] ResetWindow = 16'd100;
  localparam logic [31:0] ResetTarget = 32'd2000;

  localparam int unsigned DefRounds = 9;

  // Shared serial divider
  localparam int unsigned DivW    = 33;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  typedef enum logic [1:0] {
    StTrial = 2'd0,
    StDone  = 2'd1,
    StIdle  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRefHz  = 2'd0,
    CfgWindow = 2'd1,
    CfgTarget = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OpStart   = 1'b0,
    OpMeasure = 1'b1
  } op_e;

endpackage

// ===== rtl/core/rotb_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module rotb_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rotb_pkg::DivW-1:0]    dividend_i,
  input  logic [rotb_pkg::DivW-2:0]    divisor_i,
  output logic                         done_o,
  output logic [rotb_pkg::DivW-1:0]    quotient_o
);

  localparam int unsigned W  = rotb_pkg::DivW;
  localparam int unsigned CW = rotb_pkg::DivCntW;

  logic [W-1:0]  quo_q, quo_d;
  logic [W-2:0]  rem_q, rem_d;
  logic [W-2:0]  den_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;

  logic [W-1:0]  shifted;
  logic          ge;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? (W-1)'(shifted - {1'b0, den_q}) : shifted[W-2:0];
    quo_d   = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/ring_osc_trim_bisection_unit.sv =====
// Top level: ring oscillator trim calibration by bisection over the load capacitance.
//
// A start item (op 0) opens a bisection over 0..19960 fF and returns the first
// trial trim at 9980 fF with status 0. Each measurement item (op 1) carries the
// reference count over one calibration window: the count (forced to at least 1)
// is rounded-divided by cal_window to a per-tick count, reference_hz is divided
// by that to give freq_hz (all ones when the per-tick count or the window is
// zero), and the lower or upper bound moves to the trial load depending on
// freq_hz > target_hz. After Rounds measurements the result has status 1 and
// holds the last trial; otherwise it holds the next trial with status 0. A
// measurement while no search runs returns status 2 with zero fields. Every load
// is mapped to a coarse/fine trim (1000 fF / 160 fF steps) with the smallest
// error, earlier coarse steps winning ties. Timing: one item at a time, in_ready_o
// is high only when the sequencer is idle. Both divisions run on one shared
// restoring divider, which is loaded, builds its quotient bit by bit and hands
// it back. The trim search walks all 16 coarse steps, one per cycle, and then
// the result moves into an output register, so the next item can be accepted
// while it waits to be taken; that move waits as long as the register still
// holds an untaken result.
// Configuration writes are always taken (cfg_ready_o is tied high); write them
// only while the unit is idle.
module ring_osc_trim_bisection_unit #(
  parameter int unsigned Rounds = rotb_pkg::DefRounds
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rotb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [rotb_pkg::CountW-1:0]   count_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [rotb_pkg::CoarseW-1:0]  coarse_trim_o,
  output logic [rotb_pkg::FineW-1:0]    fine_trim_o,
  output logic [rotb_pkg::LoadW-1:0]    trial_load_o,
  output logic [rotb_pkg::FreqW-1:0]    freq_hz_o
);

  localparam int unsigned LW = rotb_pkg::LoadW;
  localparam int unsigned DW = rotb_pkg::DivW;

  typedef enum logic [2:0] {
    StIdleS,
    StDiv1,
    StDiv2,
    StUpdate,
    StTrim,
    StEmit
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] ref_hz_q;
  logic [15:0] window_q;
  logic [31:0] target_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_hz_q <= rotb_pkg::ResetRefHz;
      window_q <= rotb_pkg::ResetWindow;
      target_q <= rotb_pkg::ResetTarget;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rotb_pkg::CfgRefHz:  ref_hz_q <= cfg_data_i;
        rotb_pkg::CfgWindow: window_q <= cfg_data_i[15:0];
        rotb_pkg::CfgTarget: target_q <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e                      state_q;
  logic                        busy_q;
  logic [LW-1:0]               lower_q, upper_q, middle_q;
  logic [rotb_pkg::RoundW-1:0] round_q;
  logic [rotb_pkg::FreqW-1:0]  freq_q;
  logic [1:0]                  res_status_q;
  logic [LW-1:0]               res_load_q;

  // trim search
  logic [rotb_pkg::CoarseW-1:0] coarse_q;
  logic signed [LW:0]           rest_q;     // load - coarse*1000
  logic [LW-1:0]                min_err_q;
  logic [rotb_pkg::CoarseW-1:0] best_c_q;
  logic [rotb_pkg::FineW-1:0]   best_f_q;

  // shared divider
  logic                  div_start_q;
  logic                  div_start_d;
  logic [DW-1:0]         div_num_q;
  logic [DW-2:0]         div_den_q;
  logic                  div_done;
  logic [DW-1:0]         div_quo;

  // output register
  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic [rotb_pkg::CoarseW-1:0] out_coarse_q;
  logic [rotb_pkg::FineW-1:0]   out_fine_q;
  logic [LW-1:0]                out_load_q;
  logic [rotb_pkg::FreqW-1:0]   out_freq_q;
  logic                         emit_go;

  rotb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_num_q),
    .divisor_i  (div_den_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o = (state_q == StIdleS);
  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [rotb_pkg::CountW-1:0] cnt_clamped;
  logic [DW-1:0]               div1_num;
  logic [DW-2:0]               per_tick;

  assign cnt_clamped = (count_i == '0) ? rotb_pkg::CountW'(1) : count_i;
  // count + window/2 needs the extra bit
  assign div1_num    = {1'b0, cnt_clamped} + DW'(window_q[15:1]);
  assign per_tick    = div_quo[DW-2:0];

  // bisection step
  logic [LW-1:0]               lower_n, upper_n, middle_n;
  logic [LW:0]                 bound_sum;
  logic [rotb_pkg::RoundW-1:0] round_n;
  logic                        go_up;

  always_comb begin
    go_up     = freq_q > target_q;
    lower_n   = go_up ? middle_q : lower_q;
    upper_n   = go_up ? upper_q  : middle_q;
    bound_sum = {1'b0, lower_n} + {1'b0, upper_n};
    middle_n  = bound_sum[LW:1];
    round_n   = round_q + rotb_pkg::RoundW'(1);
  end

  // one coarse candidate per cycle: fine = round(rest/160), clamped
  logic                        cand_ok;
  logic [12:0]                 rest_rnd;
  logic [7:0]                  rest_hi;
  logic [15:0]                 recip_prod;
  logic [5:0]                  fine_raw;
  logic [rotb_pkg::FineW-1:0]  fine_cl;
  logic [12:0]                 got;
  logic [12:0]                 cand_err;

  always_comb begin
    cand_ok    = !rest_q[LW] && (rest_q[LW-1:0] < LW'(rotb_pkg::TrimWin));
    rest_rnd   = rest_q[12:0] + 13'(rotb_pkg::FineStep / 2);
    rest_hi    = rest_rnd[12:rotb_pkg::FineShift];
    recip_prod = 16'(rest_hi) * 16'(rotb_pkg::Recip5);
    fine_raw   = recip_prod[15:rotb_pkg::RecipShift];
    fine_cl    = (fine_raw > 6'(rotb_pkg::FineMax)) ? rotb_pkg::FineW'(rotb_pkg::FineMax)
                                                    : fine_raw[4:0];
    got        = 13'(fine_cl) * 13'(rotb_pkg::FineStep);
    cand_err   = (got >= rest_q[12:0]) ? (got - rest_q[12:0]) : (rest_q[12:0] - got);
  end

  // divider kicks: first division on a busy measurement with a nonzero window,
  // second once the per-tick count is known and nonzero
  assign div_start_d = (in_fire && (op_i == rotb_pkg::OpMeasure) && busy_q &&
                        (window_q != '0)) ||
                       ((state_q == StDiv1) && div_done && (per_tick != '0));

  // result moves into the output register once that register is free or its result is being taken
  assign emit_go = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdleS;
      busy_q       <= 1'b0;
      lower_q      <= '0;
      upper_q      <= LW'(rotb_pkg::LoadMax);
      middle_q     <= '0;
      round_q      <= '0;
      freq_q       <= '0;
      res_status_q <= rotb_pkg::StTrial;
      res_load_q   <= '0;
      coarse_q     <= '0;
      rest_q       <= '0;
      min_err_q    <= '0;
      best_c_q     <= '0;
      best_f_q     <= '0;
      div_start_q  <= 1'b0;
      div_num_q    <= '0;
      div_den_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_coarse_q <= '0;
      out_fine_q   <= '0;
      out_load_q   <= '0;
      out_freq_q   <= '0;
    end else begin
      div_start_q <= div_start_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdleS: begin
          if (in_fire) begin
            if (op_i == rotb_pkg::OpStart) begin
              busy_q       <= 1'b1;
              lower_q      <= '0;
              upper_q      <= LW'(rotb_pkg::LoadMax);
              round_q      <= '0;
              middle_q     <= LW'(rotb_pkg::LoadMid);
              freq_q       <= '0;
              res_status_q <= rotb_pkg::StTrial;
              res_load_q   <= LW'(rotb_pkg::LoadMid);
              coarse_q     <= '0;
              rest_q       <= {1'b0, LW'(rotb_pkg::LoadMid)};
              min_err_q    <= LW'(rotb_pkg::LoadMid);
              best_c_q     <= '0;
              best_f_q     <= '0;
              state_q      <= StTrim;
            end else if (!busy_q) begin
              // measurement with no search running
              res_status_q <= rotb_pkg::StIdle;
              res_load_q   <= '0;
              freq_q       <= '0;
              best_c_q     <= '0;
              best_f_q     <= '0;
              state_q      <= StEmit;
            end else if (window_q == '0) begin
              freq_q  <= '1;
              state_q <= StUpdate;
            end else begin
              div_num_q   <= div1_num;
              div_den_q   <= (DW-1)'(window_q);
              state_q     <= StDiv1;
            end
          end
        end

        StDiv1: begin
          if (div_done) begin
            if (per_tick == '0) begin
              freq_q  <= '1;
              state_q <= StUpdate;
            end else begin
              div_num_q   <= {1'b0, ref_hz_q};
              div_den_q   <= per_tick;
              state_q     <= StDiv2;
            end
          end
        end

        StDiv2: begin
          if (div_done) begin
            freq_q  <= div_quo[rotb_pkg::FreqW-1:0];
            state_q <= StUpdate;
          end
        end

        StUpdate: begin
          lower_q  <= lower_n;
          upper_q  <= upper_n;
          round_q  <= round_n;
          coarse_q <= '0;
          best_c_q <= '0;
          best_f_q <= '0;
          if (round_n >= rotb_pkg::RoundW'(Rounds)) begin
            // last round: report the trial just measured
            busy_q       <= 1'b0;
            res_status_q <= rotb_pkg::StDone;
            res_load_q   <= middle_q;
            rest_q       <= {1'b0, middle_q};
            min_err_q    <= middle_q;
          end else begin
            middle_q     <= middle_n;
            res_status_q <= rotb_pkg::StTrial;
            res_load_q   <= middle_n;
            rest_q       <= {1'b0, middle_n};
            min_err_q    <= middle_n;
          end
          state_q <= StTrim;
        end

        StTrim: begin
          // strict compare keeps the earlier coarse step on a tie
          if (cand_ok && (LW'(cand_err) < min_err_q)) begin
            min_err_q <= LW'(cand_err);
            best_c_q  <= coarse_q;
            best_f_q  <= fine_cl;
          end
          rest_q   <= rest_q - (LW+1)'(rotb_pkg::CoarseStep);
          coarse_q <= coarse_q + rotb_pkg::CoarseW'(1);
          if (coarse_q == rotb_pkg::CoarseW'(rotb_pkg::CoarseMax)) begin
            state_q <= StEmit;
          end
        end

        StEmit: begin
          if (emit_go) begin
            out_status_q <= res_status_q;
            out_coarse_q <= best_c_q;
            out_fine_q   <= best_f_q;
            out_load_q   <= res_load_q;
            out_freq_q   <= freq_q;
            state_q      <= StIdleS;
          end
        end

        default: state_q <= StIdleS;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign coarse_trim_o = out_coarse_q;
  assign fine_trim_o   = out_fine_q;
  assign trial_load_o  = out_load_q;
  assign freq_hz_o     = out_freq_q;

endmodule

// ===== rtl/core/rotb_checker.sv =====
// Port-level checker for the trim bisection unit, bound to the top level.
`include "assert_macros.svh"

module rotb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    status_o,
  input logic [rotb_pkg::CoarseW-1:0]  coarse_trim_o,
  input logic [rotb_pkg::FineW-1:0]    fine_trim_o,
  input logic [rotb_pkg::LoadW-1:0]    trial_load_o,
  input logic [rotb_pkg::FreqW-1:0]    freq_hz_o
);

  // one item at a time: an accepted item always takes the unit out of idle
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // a pending result is not withdrawn
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // an ignored measurement reports all-zero fields
  `ASSERT_IMPLIES(a_idle_zero, clk_i, rst_ni, out_valid_o && (status_o == rotb_pkg::StIdle), coarse_trim_o == '0 && fine_trim_o == '0 && trial_load_o == '0 && freq_hz_o == '0)

  // trial loads stay inside the search range
  `ASSERT_IMPLIES(a_load_range, clk_i, rst_ni, out_valid_o, trial_load_o <= rotb_pkg::LoadW'(rotb_pkg::LoadMax))

endmodule

bind ring_osc_trim_bisection_unit rotb_checker u_rotb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .coarse_trim_o (coarse_trim_o),
  .fine_trim_o   (fine_trim_o),
  .trial_load_o  (trial_load_o),
  .freq_hz_o     (freq_hz_o)
);

// ===== verif/ring_osc_trim_bisection_unit_tb.sv =====
// Self-checking testbench for the ring oscillator trim bisection unit.
`timescale 1ns / 1ps

module ring_osc_trim_bisection_unit_tb;
  import rotb_pkg::*;

  localparam int unsigned ROUND_LIMIT     = DefRounds;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned ITEMS_PER_PHASE = 210;

  typedef struct {
    status_e              status;
    logic [CoarseW-1:0]   coarse;
    logic [FineW-1:0]     fine;
    logic [LoadW-1:0]     load;
    logic [FreqW-1:0]     freq;
  } trim_result_t;

  // DUT ports; every input starts at a known value
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 op_i        = 1'b0;
  logic [CountW-1:0]    count_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           status_o;
  logic [CoarseW-1:0]   coarse_trim_o;
  logic [FineW-1:0]     fine_trim_o;
  logic [LoadW-1:0]     trial_load_o;
  logic [FreqW-1:0]     freq_hz_o;

  ring_osc_trim_bisection_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .count_i       (count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .coarse_trim_o (coarse_trim_o),
    .fine_trim_o   (fine_trim_o),
    .trial_load_o  (trial_load_o),
    .freq_hz_o     (freq_hz_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the calibration registers and search state
  logic [31:0]         ref_hz_cfg  = ResetRefHz;
  logic [WindowW-1:0]  window_cfg  = ResetWindow;
  logic [31:0]         target_cfg  = ResetTarget;
  logic [LoadW-1:0]    lower_load  = '0;
  logic [LoadW-1:0]    upper_load  = LoadW'(LoadMax);
  logic [LoadW-1:0]    trial_load  = '0;
  logic [RoundW-1:0]   rounds_done = '0;
  logic                cal_busy    = 1'b0;

  trim_result_t trim_expect_q[$];
  int unsigned  fail_count = 0;
  int unsigned  burst_left = 0;

  // Nearest coarse/fine pair for a load; earlier coarse step wins ties,
  // and a pair must beat the load itself to replace (0,0).
  function automatic void trim_for_load(input logic [LoadW-1:0] load,
                                        output logic [CoarseW-1:0] coarse,
                                        output logic [FineW-1:0] fine);
    int unsigned ld, first_c, last_c, min_err, c, rest, f, got, err;
    ld       = load;
    first_c  = (ld > FineStep * FineMax) ? (ld - FineStep * FineMax) / CoarseStep : 0;
    last_c   = ld / CoarseStep;
    if (last_c > CoarseMax) last_c = CoarseMax;
    min_err  = ld;
    coarse   = '0;
    fine     = '0;
    for (c = first_c; c <= last_c; c++) begin
      rest = ld - c * CoarseStep;
      f    = (rest + FineStep / 2) / FineStep;
      if (f > FineMax) f = FineMax;
      got  = c * CoarseStep + f * FineStep;
      err  = (got > ld) ? got - ld : ld - got;
      if (err < min_err) begin
        min_err  = err;
        coarse   = CoarseW'(c);
        fine     = FineW'(f);
      end
    end
  endfunction

  // Advance the search by one accepted item and return the result it causes.
  function automatic trim_result_t bisect_step(op_e op, logic [CountW-1:0] count);
    logic [63:0]      cnt, per_tick;
    logic [FreqW-1:0] freq;
    trim_result_t     r;
    r.status = StIdle;
    r.coarse = '0;
    r.fine   = '0;
    r.load   = '0;
    r.freq   = '0;
    if (op == OpStart) begin
      lower_load  = '0;
      upper_load  = LoadW'(LoadMax);
      rounds_done = '0;
      cal_busy    = 1'b1;
      trial_load  = LoadW'(({1'b0, lower_load} + {1'b0, upper_load}) >> 1);
      r.status    = StTrial;
      r.load      = trial_load;
      trim_for_load(trial_load, r.coarse, r.fine);
      return r;
    end
    // measurement with no search running leaves the state alone
    if (!cal_busy) return r;
    cnt      = (count == '0) ? 64'd1 : 64'(count);
    per_tick = (window_cfg == '0) ? 64'd0 : (cnt + 64'(window_cfg >> 1)) / 64'(window_cfg);
    freq     = (per_tick == 64'd0) ? '1 : FreqW'(64'(ref_hz_cfg) / per_tick);
    if (freq > target_cfg) lower_load = trial_load;
    else upper_load = trial_load;
    rounds_done = rounds_done + 1'b1;
    r.freq      = freq;
    if (rounds_done >= ROUND_LIMIT) begin
      cal_busy = 1'b0;
      r.status = StDone;
    end else begin
      trial_load = LoadW'(({1'b0, lower_load} + {1'b0, upper_load}) >> 1);
      r.status   = StTrial;
    end
    r.load = trial_load;
    trim_for_load(trial_load, r.coarse, r.fine);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Offer one item; bursts of back-to-back items are mostly broken by random gaps.
  task automatic send_item(op_e op, logic [CountW-1:0] count);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i       <= op;
    count_i    <= count;
    do @(posedge clk_i); while (!in_ready_o);
    trim_expect_q.push_back(bisect_step(op, count));
  endtask

  // Drop valid, let every pending result drain, then give the sequencer time.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (trim_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers back to back while the unit is idle.
  task automatic set_config(logic [31:0] ref_hz, logic [31:0] window, logic [31:0] target);
    cfg_idx_e    order[3];
    logic [31:0] vals[3];
    order = '{CfgRefHz, CfgWindow, CfgTarget};
    vals  = '{ref_hz, window, target};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (order[i])
        CfgRefHz:  ref_hz_cfg = vals[i];
        CfgWindow: window_cfg = vals[i][WindowW-1:0];
        CfgTarget: target_cfg = vals[i];
        default:   ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Count stimulus: bias 0 pushes the frequency up, 1 pushes it down,
  // anything else mixes full-range, small and near-threshold counts.
  function automatic logic [CountW-1:0] pick_count(int unsigned bias);
    logic [63:0] thr, v;
    if (bias == 0) return CountW'($urandom_range(0, 3));
    if (bias == 1) return {16'hFFFF, 16'($urandom)};
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return CountW'($urandom_range(0, 1000));
      default: begin
        thr = (target_cfg == '0) ? 64'hFFFF_FFFF
                                 : (64'(window_cfg) * 64'(ref_hz_cfg)) / 64'(target_cfg);
        if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
        v = thr * (900 + $urandom_range(0, 200)) / 1000 + $urandom_range(0, 8);
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        return v[CountW-1:0];
      end
    endcase
  endfunction

  // Result checker: compare each taken result with the oldest expectation.
  trim_result_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (trim_expect_q.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = trim_expect_q.pop_front();
        check_field("status", 32'(status_o), 32'(want.status));
        check_field("coarse_trim", 32'(coarse_trim_o), 32'(want.coarse));
        check_field("fine_trim", 32'(fine_trim_o), 32'(want.fine));
        check_field("trial_load", 32'(trial_load_o), 32'(want.load));
        check_field("freq_hz", freq_hz_o, want.freq);
      end
    end
  end

  // Receiver: changes stall style now and then; a long hold-off on request.
  // A request is a toggle of hold_req, seen as a difference from hold_ack.
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  logic        run_state = 1'b1;
  int unsigned hold_left = 0;
  int unsigned mode      = 0;
  int unsigned mode_left = 0;
  int unsigned run_left  = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (run_left == 0) begin
        run_state = ~run_state;
        run_left  = $urandom_range(1, 12);
      end
      run_left--;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= run_state;
      endcase
    end
  end

  // Watchdog
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle measurements, zero and all-ones counts, restart mid-search.
  task automatic test_idle_and_restart();
    send_item(OpMeasure, '0);
    send_item(OpMeasure, '1);
    send_item(OpStart, '1);
    send_item(OpMeasure, '0);   // count forced to 1, per-tick rounds to 0
    send_item(OpMeasure, '1);   // count plus half window past 32 bits
    send_item(OpStart, '0);     // restart while busy
  endtask

  // One complete search to the done item, then a stray measurement.
  task automatic test_full_search();
    for (int k = 0; k < ROUND_LIMIT; k++)
      send_item(OpMeasure, (k % 2 != 0) ? 32'd2_000_000 : 32'd1_000_000);
    send_item(OpMeasure, 32'd12345);
  endtask

  // Register extremes: zero window (junk in the upper data bits), max target,
  // widest window, zero target, zero reference.
  task automatic test_register_extremes();
    set_config('1, 32'hFFFF_0000, '1);
    send_item(OpStart, '0);
    send_item(OpMeasure, 32'd777);
    set_config(32'd1, 32'd65535, '0);
    send_item(OpStart, '0);
    send_item(OpMeasure, 32'd1);
    send_item(OpMeasure, '1);
    set_config('0, 32'd1, '0);
    send_item(OpStart, '0);
    send_item(OpMeasure, 32'd5);
  endtask

  // Receiver holds off while a search is fed, so the unit backs up its input.
  task automatic test_output_backpressure();
    settle();
    hold_req = ~hold_req;
    send_item(OpStart, '0);
    for (int k = 0; k < ROUND_LIMIT; k++) send_item(OpMeasure, pick_count(2));
    send_item(OpMeasure, $urandom);
  endtask

  // Mostly complete searches with random counts; some cut short, some noise.
  task automatic run_random_phase(int unsigned n_items);
    int unsigned done_items, rounds, bias;
    done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0) begin
          if (cal_busy) done_items++;
          send_item(OpMeasure, $urandom);
        end else begin
          send_item(OpStart, $urandom);
          done_items++;
        end
      end else begin
        bias   = $urandom_range(0, 3);
        rounds = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ROUND_LIMIT - 1)
                                             : ROUND_LIMIT;
        send_item(OpStart, $urandom);
        done_items++;
        for (int k = 0; k < rounds; k++) begin
          send_item(OpMeasure, pick_count(bias));
          done_items++;
        end
      end
    end
  endtask

  task automatic test_random_phases();
    set_config(ResetRefHz, 32'(ResetWindow), ResetTarget);
    run_random_phase(ITEMS_PER_PHASE);
    set_config($urandom, {16'($urandom), 16'($urandom_range(1, 65535))}, $urandom);
    run_random_phase(ITEMS_PER_PHASE);
    set_config('1, 32'd1, $urandom);
    run_random_phase(ITEMS_PER_PHASE);
    set_config(32'd1, 32'd65535, '0);
    run_random_phase(ITEMS_PER_PHASE);
    set_config($urandom, 32'd0, $urandom);
    run_random_phase(ITEMS_PER_PHASE);
    set_config($urandom_range(1000, 100_000_000), $urandom_range(1, 1000),
               $urandom_range(100, 100_000));
    run_random_phase(ITEMS_PER_PHASE);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_and_restart();
    test_full_search();
    test_register_extremes();
    test_output_backpressure();
    test_random_phases();
    settle();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
